/* rtl/core/button_press_classifier_unit_macros.svh */
// Assertion macros shared by the checker of the button press classifier.
// No dependencies; included by the files that carry assertions.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Implication that is checked only while out of reset.
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked only while out of reset.
`define BPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked at every edge, reset included.
`define BPC_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bpc_pkg.sv */
// Package of the button press classifier: widths, register codes, beat types
// and the state token that travels along the row of cells. No dependencies.
`default_nettype none

package bpc_pkg;

    localparam int NUM_INPUTS = 8;
    localparam int FIELD_W    = 8;
    localparam int CNT_W      = 16;
    localparam int OWNER_W    = 4;
    localparam int DEB_W      = 10;
    localparam int DWIN_W     = 12;
    localparam int LONG_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [OWNER_W-1:0] OWNER_NONE = OWNER_W'(8);

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = DEB_W'(50);
    localparam logic [DWIN_W-1:0] DWIN_RESET     = DWIN_W'(500);
    localparam logic [LONG_W-1:0] LONG_RESET     = LONG_W'(1500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PUSHBUTTON_MASK = 3'd0,
        CFG_SWITCH_MASK     = 3'd1,
        CFG_DEBOUNCE        = 3'd2,
        CFG_DOUBLE_WINDOW   = 3'd3,
        CFG_LONG_PRESS      = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [FIELD_W-1:0] levels;
        logic [FIELD_W-1:0] changed;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] single_press;
        logic [FIELD_W-1:0] double_press;
        logic [FIELD_W-1:0] long_press;
        logic [FIELD_W-1:0] switch_on;
        logic [FIELD_W-1:0] switch_off;
    } t_out;

    // Timing thresholds seen by every cell.
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [DWIN_W-1:0] double_window_ms;
        logic [LONG_W-1:0] long_press_ms;
    } t_cfg;

    // Shared state as one input leaves it for the next.
    typedef struct packed {
        logic [CNT_W-1:0]   since_change;
        logic [CNT_W-1:0]   since_release;
        logic [CNT_W-1:0]   since_press;
        logic [OWNER_W-1:0] double_owner;
        logic [OWNER_W-1:0] long_owner;
        logic               skip_release;
    } t_shared;

    typedef struct packed {
        logic    valid;
        t_shared st;
    } t_token;

    // Pulses of one input for one tick.
    typedef struct packed {
        logic single_press;
        logic double_press;
        logic long_press;
        logic switch_on;
        logic switch_off;
    } t_pulse;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/button_press_classifier_unit.sv */
// Button press classifier: one tick a beat in, one pulse set a beat out, with
// a row of bpc_cell instances that each handle one input. Depends on bpc_pkg.
//
// Each input beat is one tick. The shared state token enters the row with its
// counters advanced and moves one cell a cycle. After the last cell the tick
// is marked done, then moved into the output register, which raises the output
// valid and frees the input for the next beat. When the output is not held
// off, the walk along the row sets the rate. One tick is in the row at a time:
// the next beat is taken once the previous result has moved into the output
// register, even while that result still waits to be taken. Registers are
// written through the plain write port; indexes beyond the five registers are
// ignored.
`default_nettype none

module button_press_classifier_unit
    import bpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [FIELD_W-1:0] r_pb_mask;
    logic [FIELD_W-1:0] r_sw_mask;
    t_cfg               r_cfg;

    t_shared            r_state;
    t_in                r_in;
    logic               r_busy;
    logic               r_start;
    logic               r_done;
    logic               r_out_valid;
    t_out               r_out;
    t_out               n_out;

    t_token             w_tok [NUM_INPUTS+1];
    t_pulse             w_pulse [NUM_INPUTS];
    logic               in_acc;
    logic               out_free;

    assign in_acc   = i_in_valid && !r_busy;
    assign out_free = !r_out_valid || i_out_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_mask              <= '0;
            r_sw_mask              <= '0;
            r_cfg.debounce_ms      <= DEBOUNCE_RESET;
            r_cfg.double_window_ms <= DWIN_RESET;
            r_cfg.long_press_ms    <= LONG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PUSHBUTTON_MASK: r_pb_mask <= i_cfg_data[FIELD_W-1:0];
                CFG_SWITCH_MASK:     r_sw_mask <= i_cfg_data[FIELD_W-1:0];
                CFG_DEBOUNCE:        r_cfg.debounce_ms <= i_cfg_data[DEB_W-1:0];
                CFG_DOUBLE_WINDOW:   r_cfg.double_window_ms <= i_cfg_data[DWIN_W-1:0];
                CFG_LONG_PRESS:      r_cfg.long_press_ms <= i_cfg_data[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // The counters advance once per tick before the first input sees them.
    always_comb begin
        w_tok[0]                  = '0;
        w_tok[0].valid            = r_start;
        w_tok[0].st               = r_state;
        w_tok[0].st.since_change  = sat_inc(r_state.since_change);
        w_tok[0].st.since_release = sat_inc(r_state.since_release);
        w_tok[0].st.since_press   = sat_inc(r_state.since_press);
    end

    for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_cell
        logic pb;
        logic sw;
        logic lvl;
        logic chg;

        if (i < FIELD_W) begin : g_live
            assign pb  = r_pb_mask[i];
            assign sw  = r_sw_mask[i];
            assign lvl = r_in.levels[i];
            assign chg = r_in.changed[i];
        end else begin : g_pad
            assign pb  = 1'b0;
            assign sw  = 1'b0;
            assign lvl = 1'b0;
            assign chg = 1'b0;
        end

        bpc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (OWNER_W'(i)),
            .i_cfg     (r_cfg),
            .i_pb      (pb),
            .i_sw      (sw),
            .i_level   (lvl),
            .i_changed (chg),
            .i_tok     (w_tok[i]),
            .o_tok     (w_tok[i+1]),
            .o_pulse   (w_pulse[i])
        );
    end

    // Gather the per-input pulses into the output masks.
    for (genvar i = 0; i < FIELD_W; i++) begin : g_gather
        if (i < NUM_INPUTS) begin : g_used
            assign n_out.single_press[i] = w_pulse[i].single_press;
            assign n_out.double_press[i] = w_pulse[i].double_press;
            assign n_out.long_press[i]   = w_pulse[i].long_press;
            assign n_out.switch_on[i]    = w_pulse[i].switch_on;
            assign n_out.switch_off[i]   = w_pulse[i].switch_off;
        end else begin : g_unused
            assign n_out.single_press[i] = 1'b0;
            assign n_out.double_press[i] = 1'b0;
            assign n_out.long_press[i]   = 1'b0;
            assign n_out.switch_on[i]    = 1'b0;
            assign n_out.switch_off[i]   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy                <= 1'b0;
            r_start               <= 1'b0;
            r_done                <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.since_change  <= CNT_MAX;
            r_state.since_release <= CNT_MAX;
            r_state.since_press   <= CNT_MAX;
            r_state.double_owner  <= OWNER_NONE;
            r_state.long_owner    <= OWNER_NONE;
            r_state.skip_release  <= 1'b0;
        end else begin
            r_start <= in_acc;
            if (in_acc) begin
                r_busy <= 1'b1;
            end
            if (w_tok[NUM_INPUTS].valid) begin
                r_state <= w_tok[NUM_INPUTS].st;
                r_done  <= 1'b1;
            end
            // A finished tick waits in the cells until the output register frees.
            if (r_done && out_free) begin
                r_done      <= 1'b0;
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (r_done && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/core/bpc_cell.sv */
// One cell of the classifier row: handles a single input and hands the
// updated shared state to its neighbour. Depends on bpc_pkg.
`default_nettype none

module bpc_cell
    import bpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [OWNER_W-1:0] i_index,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_pb,
    input  wire logic               i_sw,
    input  wire logic               i_level,
    input  wire logic               i_changed,
    input  wire t_token             i_tok,
    output t_token                  o_tok,
    output t_pulse                  o_pulse
);

    t_token  r_tok;
    t_pulse  r_pulse;
    t_shared n_st;
    t_pulse  n_pulse;
    logic    ch;

    always_comb begin
        n_st    = i_tok.st;
        n_pulse = '0;
        ch      = i_changed;

        if (i_pb && (n_st.since_change < CNT_W'(i_cfg.debounce_ms))) begin
            ch = 1'b0;
        end
        // The change that follows a long press is swallowed on any input.
        if (n_st.skip_release && ch) begin
            n_st.since_change = '0;
            n_st.skip_release = 1'b0;
            ch                = 1'b0;
        end
        if (i_pb && ch && !i_level) begin
            if (n_st.since_release >= CNT_W'(i_cfg.double_window_ms)) begin
                n_st.since_release   = '0;
                n_st.double_owner    = i_index;
                n_pulse.single_press = 1'b1;
            end else if (n_st.double_owner == i_index) begin
                n_pulse.double_press = 1'b1;
            end else begin
                n_pulse.single_press = 1'b1;
            end
        end
        if (i_pb && ch && i_level) begin
            n_st.since_press = '0;
            n_st.long_owner  = i_index;
        end
        if (i_pb && i_level && (n_st.long_owner == i_index) && !n_st.skip_release
                && (n_st.since_press >= i_cfg.long_press_ms)) begin
            n_pulse.long_press = 1'b1;
            n_st.skip_release  = 1'b1;
        end
        if (!i_pb && i_sw && ch) begin
            n_pulse.single_press = 1'b1;
            n_pulse.switch_on    = i_level;
            n_pulse.switch_off   = !i_level;
        end
        if (ch) begin
            n_st.since_change = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.st <= n_st;
        if (i_tok.valid) begin
            r_pulse <= n_pulse;
        end
    end

    assign o_tok   = r_tok;
    assign o_pulse = r_pulse;

endmodule

`default_nettype wire

/* rtl/core/bpc_checker.sv */
// Port-level checker for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier_unit_macros.svh.
`default_nettype none

`include "button_press_classifier_unit_macros.svh"

module bpc_checker
    import bpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  o_in_ready,
    input  wire t_in                   i_in_data,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic in_beat;
    logic cfg_seen;
    logic pulses_ok;

    assign in_beat  = i_in_valid && o_in_ready;
    assign cfg_seen = i_cfg_we && (i_cfg_index != '0 || i_cfg_data != '1 || i_in_data != '1);

    // An input never reports two kinds of press, and switch pulses come with a
    // single press and never with a pushbutton pulse.
    assign pulses_ok =
        ((o_out_data.single_press & o_out_data.double_press) == '0) &&
        ((o_out_data.single_press & o_out_data.long_press) == '0) &&
        ((o_out_data.switch_on & o_out_data.switch_off) == '0) &&
        (((o_out_data.switch_on | o_out_data.switch_off) & ~o_out_data.single_press) == '0) &&
        (((o_out_data.switch_on | o_out_data.switch_off) &
          (o_out_data.double_press | o_out_data.long_press)) == '0);

    `BPC_ASSERT_NXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")
    `BPC_ASSERT_NXT(a_one_tick_at_a_time, i_clk, i_rst_n, in_beat, !o_in_ready, "beat taken while tick in progress")
    `BPC_ASSERT_IMP(a_pulse_masks, i_clk, i_rst_n, o_out_valid || cfg_seen, !o_out_valid || pulses_ok, "inconsistent pulse masks")
    `BPC_ASSERT_NXT(a_out_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat dropped or changed while stalled")

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

/* test/bpc_pulse_checker.sv */
// Pulse checker for the button press classifier: follows the register port and
// both beat channels, predicts each tick's pulse set and compares it on output.
// Depends on bpc_pkg only.

module bpc_pulse_checker
    import bpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in                   i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out                  i_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_errors
);

    // Register copies.
    logic [FIELD_W-1:0] pb_mask;
    logic [FIELD_W-1:0] sw_mask;
    logic [DEB_W-1:0]   debounce;
    logic [DWIN_W-1:0]  dbl_window;
    logic [LONG_W-1:0]  long_hold;

    // Shared tick state.
    logic [CNT_W-1:0]   ticks_since_change;
    logic [CNT_W-1:0]   ticks_since_release;
    logic [CNT_W-1:0]   ticks_since_press;
    logic [OWNER_W-1:0] window_owner;
    logic [OWNER_W-1:0] hold_owner;
    logic               skip_next;

    t_out expected_pulses[$];
    int   mismatch_count = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Works out the pulse set of one tick and moves the shared state on.
    function automatic t_out classify_tick(input t_in tick);
        t_out res;
        logic pb, sw, lvl, chg;
        res = '0;
        ticks_since_change  = bump(ticks_since_change);
        ticks_since_release = bump(ticks_since_release);
        ticks_since_press   = bump(ticks_since_press);
        for (int i = 0; i < NUM_INPUTS; i++) begin
            pb  = pb_mask[i];
            sw  = !pb && sw_mask[i];
            lvl = tick.levels[i];
            chg = tick.changed[i];
            if (pb && ticks_since_change < CNT_W'(debounce))
                chg = 1'b0;
            // The change after a long press is swallowed, whatever the input.
            if (skip_next && chg) begin
                ticks_since_change = '0;
                chg = 1'b0;
                skip_next = 1'b0;
            end
            if (pb && chg && !lvl) begin
                res.single_press[i] = 1'b1;
                if (ticks_since_release >= CNT_W'(dbl_window)) begin
                    ticks_since_release = '0;
                    window_owner = OWNER_W'(i);
                end else if (window_owner == OWNER_W'(i)) begin
                    res.double_press[i] = 1'b1;
                    res.single_press[i] = 1'b0;
                end
            end
            if (pb && chg && lvl) begin
                ticks_since_press = '0;
                hold_owner = OWNER_W'(i);
            end
            if (pb && lvl && hold_owner == OWNER_W'(i) && !skip_next &&
                ticks_since_press >= CNT_W'(long_hold)) begin
                res.long_press[i] = 1'b1;
                skip_next = 1'b1;
            end
            if (sw && chg) begin
                res.single_press[i] = 1'b1;
                if (lvl)
                    res.switch_on[i] = 1'b1;
                else
                    res.switch_off[i] = 1'b1;
            end
            if (chg)
                ticks_since_change = '0;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pb_mask             = '0;
            sw_mask             = '0;
            debounce            = DEBOUNCE_RESET;
            dbl_window          = DWIN_RESET;
            long_hold           = LONG_RESET;
            ticks_since_change  = CNT_MAX;
            ticks_since_release = CNT_MAX;
            ticks_since_press   = CNT_MAX;
            window_owner        = OWNER_NONE;
            hold_owner          = OWNER_NONE;
            skip_next           = 1'b0;
            expected_pulses.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PUSHBUTTON_MASK: pb_mask    = i_cfg_data[FIELD_W-1:0];
                    CFG_SWITCH_MASK:     sw_mask    = i_cfg_data[FIELD_W-1:0];
                    CFG_DEBOUNCE:        debounce   = i_cfg_data[DEB_W-1:0];
                    CFG_DOUBLE_WINDOW:   dbl_window = i_cfg_data[DWIN_W-1:0];
                    CFG_LONG_PRESS:      long_hold  = i_cfg_data[LONG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_pulses.push_back(classify_tick(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_pulses.size() == 0) begin
                    $display("%0t: beat %h expected none actual %h", $time,
                             i_out_data, i_out_data);
                    mismatch_count++;
                end else begin
                    want = expected_pulses.pop_front();
                    check_field("single_press", want.single_press, i_out_data.single_press);
                    check_field("double_press", want.double_press, i_out_data.double_press);
                    check_field("long_press", want.long_press, i_out_data.long_press);
                    check_field("switch_on", want.switch_on, i_out_data.switch_on);
                    check_field("switch_off", want.switch_off, i_out_data.switch_off);
                end
            end
        end
        o_pending <= expected_pulses.size();
        o_errors  <= mismatch_count;
    end

endmodule

/* test/tb_top.sv */
// Top of the button press classifier bench: clock, reset, register writes,
// tick stimulus and output back-pressure, and the verdict.
// Depends on bpc_pkg, button_press_classifier_unit and bpc_pulse_checker.

module tb_top;
    import bpc_pkg::*;

    localparam int LATENCY     = NUM_INPUTS + 3;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 108;
    localparam logic [DEB_W-1:0]  DEB_MAX  = {DEB_W{1'b1}};
    localparam logic [DWIN_W-1:0] DWIN_MAX = {DWIN_W{1'b1}};
    localparam logic [LONG_W-1:0] LONG_MAX = {LONG_W{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    errors;

    // Sender's view of the input levels, and the knobs of the current phase.
    logic [FIELD_W-1:0] held;
    logic [FIELD_W-1:0] active;
    int                 toggle_odds;
    int                 sender_odds;
    int                 rx_odds;
    bit                 quiet = 1'b0;
    bit                 hold_pending = 1'b0;

    always #1 clk = ~clk;

    button_press_classifier_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bpc_pulse_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Bits above the register width carry junk; the block must drop them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (width >= CFG_DATA_W) ? value
                                           : ((CFG_DATA_W'($urandom) << width) | value);
        @(posedge clk);
    endtask

    task automatic configure(input logic [FIELD_W-1:0] pb, input logic [FIELD_W-1:0] sw,
                             input logic [DEB_W-1:0] deb, input logic [DWIN_W-1:0] dwin,
                             input logic [LONG_W-1:0] hold);
        write_reg(CFG_PUSHBUTTON_MASK, CFG_DATA_W'(pb), FIELD_W);
        write_reg(CFG_SWITCH_MASK, CFG_DATA_W'(sw), FIELD_W);
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb), DEB_W);
        write_reg(CFG_DOUBLE_WINDOW, CFG_DATA_W'(dwin), DWIN_W);
        write_reg(CFG_LONG_PRESS, CFG_DATA_W'(hold), LONG_W);
        write_reg(CFG_IDX_W'($urandom_range(CFG_LONG_PRESS + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom), CFG_DATA_W);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input t_in beat);
        if (!quiet && sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
    endtask

    // Waits until every pulse set has come back, then lets the row empty.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Mostly clean level toggles on the active inputs; some raw noise and some
    // change flags that do not match a level change.
    function automatic t_in next_tick();
        t_in beat;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            beat.levels  = FIELD_W'($urandom);
            beat.changed = FIELD_W'($urandom);
            held = beat.levels;
        end else if (pick < 12) begin
            beat.levels  = held;
            beat.changed = FIELD_W'($urandom & $urandom);
        end else begin
            beat.changed = '0;
            for (int i = 0; i < FIELD_W; i++) begin
                if (active[i] && $urandom_range(1, toggle_odds) == 1) begin
                    held[i] = ~held[i];
                    beat.changed[i] = 1'b1;
                end
            end
            beat.levels = held;
        end
        return beat;
    endfunction

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = 400;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (idle_left != 0) begin
                idle_left--;
                out_ready <= 1'b0;
            end else if (!quiet && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
                idle_left = $urandom_range(1, 18) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int count;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        held        = '0;
        active      = '1;
        toggle_odds = 8;
        sender_odds = 4;
        rx_odds     = 4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Long press then a swallowed release, a single then a double press,
        // switch on and off, untyped inputs, and a busy tick where later
        // pushbuttons fall inside the debounce window.
        configure(8'h0F, 8'h33, 10'd1, 12'd6, 16'd3);
        send_tick(t_in'{8'h01, 8'h01});
        send_tick(t_in'{8'h01, 8'h00});
        send_tick(t_in'{8'h01, 8'h00});
        send_tick(t_in'{8'h01, 8'h00});
        send_tick(t_in'{8'h00, 8'h01});
        send_tick(t_in'{8'h00, 8'h00});
        send_tick(t_in'{8'h04, 8'h04});
        send_tick(t_in'{8'h00, 8'h04});
        send_tick(t_in'{8'h04, 8'h04});
        send_tick(t_in'{8'h00, 8'h04});
        send_tick(t_in'{8'h10, 8'h10});
        send_tick(t_in'{8'h00, 8'h10});
        send_tick(t_in'{8'hC0, 8'hC0});
        send_tick(t_in'{8'hFF, 8'hFF});
        send_tick(t_in'{8'h00, 8'hFF});
        settle();

        // Zero thresholds: a long press in the tick of its press, and the
        // skip taken by a switch change.
        configure(8'h81, 8'h7E, '0, '0, '0);
        send_tick(t_in'{8'h01, 8'h01});
        send_tick(t_in'{8'h03, 8'h02});
        send_tick(t_in'{8'h00, 8'h01});
        send_tick(t_in'{8'h00, 8'h80});
        settle();

        // Largest thresholds and masks.
        configure(8'hFF, 8'hFF, DEB_MAX, DWIN_MAX, LONG_MAX);
        send_tick(t_in'{8'hFF, 8'hFF});
        send_tick(t_in'{8'h00, 8'h00});
        settle();
        configure(8'h00, 8'hFF, DEB_MAX, DWIN_MAX, LONG_MAX);
        send_tick(t_in'{8'hAA, 8'hFF});
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            count = PHASE_ITEMS;
            if (p == 1) begin
                configure('0, '0, '0, '0, '0);
            end else if (p == 5) begin
                configure('1, '0, DEB_MAX, DWIN_MAX, LONG_MAX);
                count = 30;
            end else begin
                configure(FIELD_W'($urandom), FIELD_W'($urandom),
                          DEB_W'($urandom_range(0, 3)), DWIN_W'($urandom_range(0, 30)),
                          LONG_W'($urandom_range(0, 24)));
            end
            active      = FIELD_W'($urandom_range(1, 255));
            toggle_odds = $urandom_range(3, 24);
            sender_odds = (p % 4 == 2) ? 0 : $urandom_range(2, 8);
            rx_odds     = (p % 4 == 0) ? 0 : $urandom_range(2, 8);
            if (p == 3) begin
                // The receiver goes quiet while beats keep coming, so the
                // block fills up and has to hold its input off.
                sender_odds  = 0;
                hold_pending = 1'b1;
            end
            if (p == RAND_PHASES - 1)
                quiet = 1'b1;
            repeat (count) send_tick(next_tick());
            settle();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
